// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define BAS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define BAS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bas_pkg.sv =====
// shared types and constants of the byte alu stream
`timescale 1ns / 1ps

package bas_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_OR   = 4'd4,
    OP_AND  = 4'd5,
    OP_XOR  = 4'd6,
    OP_SHL  = 4'd7,
    OP_SAL  = 4'd8,
    OP_SHR  = 4'd9,
    OP_SAR  = 4'd10,
    OP_ROL  = 4'd11,
    OP_ROR  = 4'd12,
    OP_PERM = 4'd13
  } op_t;

  localparam logic [1:0] REG_OP_SELECT     = 2'd0;
  localparam logic [1:0] REG_OPERAND_VALUE = 2'd1;
  localparam logic [1:0] REG_BIT_MAP       = 2'd2;

  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] IDENTITY_MAP = 24'hFAC688;

  localparam byte_t SHL_MASK = 8'hFE;
  localparam byte_t SHR_MASK = 8'h7F;

  localparam logic [7:0][2:0] UP_MAP =
    {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0};
  localparam logic [7:0][2:0] DOWN_MAP =
    {3'd7, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};
  localparam logic [7:0][2:0] ROTL_MAP =
    {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd7};
  localparam logic [7:0][2:0] ROTR_MAP =
    {3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1};

endpackage

// ===== rtl/bas_in_if.sv =====
// input word channel of the byte alu stream
`timescale 1ns / 1ps

interface bas_in_if
  import bas_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_in;

  modport source (output valid, output data_byte, output last_in, input ready);
  modport sink   (input valid, input data_byte, input last_in, output ready);
endinterface

// ===== rtl/bas_out_if.sv =====
// output word channel of the byte alu stream
`timescale 1ns / 1ps

interface bas_out_if
  import bas_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t result_byte;
  logic  last_out;

  modport source (output valid, output result_byte, output last_out, input ready);
  modport sink   (input valid, input result_byte, input last_out, output ready);
endinterface

// ===== rtl/byte_alu_stream.sv =====
// byte alu stream: one configured operation applied to every byte word
`timescale 1ns / 1ps
//
// in_stream carries a byte and a last flag, out_stream returns one result
// word per input word, in order, with the last flag copied through.
// the operation, operand and bit map come from the write port
// (cfg_we, cfg_index, cfg_data); write them only while the block is empty.
// a four-stage pipeline: operand prep and all non-divide operations,
// then two stages of three restoring divide steps, then two more steps,
// sign fix and result select into the output register.
// one word enters every cycle while the receiver keeps up; the divide steps
// set the stage depth.
// each stage moves when its successor is empty or moving, so a stalled
// receiver holds the output word and the pipeline fills its bubbles
// before in_stream.ready drops.
// rst clears all valid bits and loads the default configuration:
// add, operand zero, identity bit map.

module byte_alu_stream
  import bas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bas_in_if.sink                in_stream,
  bas_out_if.source             out_stream
);

  typedef struct packed {
    logic        last;
    logic        is_div;
    logic        neg;
    byte_t       res;
    byte_t       dsh;
    byte_t       rem;
    byte_t       quo;
    logic [15:0] amag;
  } stage_t;

  function automatic byte_t gather(byte_t b, logic [7:0][2:0] m);
    byte_t r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[m[i]];
    end
    return r;
  endfunction

  function automatic stage_t div_step(stage_t s);
    stage_t      t;
    logic [8:0]  part;
    logic [8:0]  diff;
    t    = s;
    part = {s.rem, s.dsh[7]};
    diff = part - s.amag[8:0];
    if ({7'd0, part} >= s.amag) begin
      t.rem = diff[7:0];
      t.quo = {s.quo[6:0], 1'b1};
    end else begin
      t.rem = part[7:0];
      t.quo = {s.quo[6:0], 1'b0};
    end
    t.dsh = {s.dsh[6:0], 1'b0};
    return t;
  endfunction

  logic [3:0]  op_select;
  logic [15:0] operand_value;
  logic [23:0] bit_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_select     <= 4'(OP_ADD);
      operand_value <= 16'd0;
      bit_map       <= IDENTITY_MAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OP_SELECT:     op_select     <= cfg_data[3:0];
        REG_OPERAND_VALUE: operand_value <= cfg_data[15:0];
        REG_BIT_MAP:       bit_map       <= cfg_data;
        default:           ;
      endcase
    end
  end

  logic   v1, v2, v3, vo;
  logic   go1, go2, go3, goo;
  stage_t s1, s2, s3;
  stage_t s1_next, s2_next, s3_next, so_next;
  byte_t  result_byte;
  logic   last_out;

  assign goo = !vo || out_stream.ready;
  assign go3 = !v3 || goo;
  assign go2 = !v2 || go3;
  assign go1 = !v1 || go2;

  assign in_stream.ready = go1;

  byte_t       d;
  byte_t       a_lo;

  assign d    = in_stream.data_byte;
  assign a_lo = operand_value[7:0];

  always_comb begin
    s1_next        = '0;
    s1_next.last   = in_stream.last_in;
    s1_next.neg    = d[7] ^ operand_value[15];
    s1_next.dsh    = d[7] ? byte_t'(-d) : d;
    s1_next.amag   = operand_value[15] ? 16'(-operand_value) : operand_value;
    s1_next.is_div = (op_t'(op_select) == OP_DIV) && (operand_value != 16'd0);
    case (op_t'(op_select))
      OP_ADD:  s1_next.res = d + a_lo;
      OP_SUB:  s1_next.res = d - a_lo;
      OP_MUL:  s1_next.res = d * a_lo;
      OP_DIV:  s1_next.res = d;
      OP_OR:   s1_next.res = d | a_lo;
      OP_AND:  s1_next.res = d & a_lo;
      OP_XOR:  s1_next.res = d ^ a_lo;
      OP_SHL:  s1_next.res = gather(d, UP_MAP) & SHL_MASK;
      OP_SAL:  s1_next.res = gather(d, UP_MAP);
      OP_SHR:  s1_next.res = gather(d, DOWN_MAP) & SHR_MASK;
      OP_SAR:  s1_next.res = gather(d, DOWN_MAP);
      OP_ROL:  s1_next.res = gather(d, ROTL_MAP);
      OP_ROR:  s1_next.res = gather(d, ROTR_MAP);
      OP_PERM: s1_next.res = gather(d, bit_map);
      default: s1_next.res = 8'd0;
    endcase
  end

  always_comb begin
    s2_next = div_step(div_step(div_step(s1)));
    s3_next = div_step(div_step(div_step(s2)));
    so_next = div_step(div_step(s3));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (go1) v1 <= in_stream.valid;
      if (go2) v2 <= v1;
      if (go3) v3 <= v2;
      if (goo) vo <= v3;
    end
    if (go1) s1 <= s1_next;
    if (go2) s2 <= s2_next;
    if (go3) s3 <= s3_next;
    if (goo) begin
      last_out <= s3.last;
      if (so_next.is_div) begin
        result_byte <= so_next.neg ? byte_t'(-so_next.quo) : so_next.quo;
      end else begin
        result_byte <= so_next.res;
      end
    end
  end

  assign out_stream.valid       = vo;
  assign out_stream.result_byte = result_byte;
  assign out_stream.last_out    = last_out;

endmodule

// ===== rtl/bas_checker.sv =====
// port-level checker of the byte alu stream and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bas_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] result_byte,
  input logic       last_out
);

  `BAS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "output word dropped while stalled")
  `BAS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(result_byte) && $stable(last_out), "output word changed while stalled")
  `BAS_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid, "output valid after reset")
  `BAS_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input blocked with empty output")
  `BAS_ASSERT_NOW(a_backpressure_cause, clk, rst, !in_ready, out_valid && !out_ready, "input blocked without output stall")

endmodule

bind byte_alu_stream bas_checker u_bas_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_stream.ready),
  .out_valid   (out_stream.valid),
  .out_ready   (out_stream.ready),
  .result_byte (out_stream.result_byte),
  .last_out    (out_stream.last_out)
);

// ===== tb/sv/tb.sv =====
// testbench for byte_alu_stream: directed table plus random config phases, checked by a predictor
`timescale 1ns / 1ps

module tb;
  import bas_pkg::*;

  localparam logic [3:0] OP_UNDEF_LO = 4'd14;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;
  localparam int PIPE_DEPTH = 4;
  localparam int IDLE_PCT = 38;
  localparam int HOLD_CYCLES = 48;
  localparam int QUIET_LIMIT = 4000;
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_WORDS = 1600;
  localparam logic [23:0] REVERSE_MAP = 24'h053977;

  typedef struct packed {
    byte_t result_byte;
    logic  last_out;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] operand;
    logic [23:0] map;
    byte_t       data;
    logic        last;
    logic        known;
    byte_t       result;
  } vector_t;

  vector_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_ADD,      16'h0000, IDENTITY_MAP, 8'h00, 1'b0, 1'b1, 8'h00},
    '{OP_ADD,      16'h0000, IDENTITY_MAP, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{OP_ADD,      16'h7FFF, IDENTITY_MAP, 8'h01, 1'b0, 1'b1, 8'h00},
    '{OP_SUB,      16'h8000, IDENTITY_MAP, 8'hFF, 1'b1, 1'b1, 8'hFF},
    '{OP_MUL,      16'hFFFF, IDENTITY_MAP, 8'h80, 1'b0, 1'b0, 8'h00},
    '{OP_DIV,      16'h0000, IDENTITY_MAP, 8'hA5, 1'b0, 1'b1, 8'hA5},
    '{OP_DIV,      16'hFFFF, IDENTITY_MAP, 8'h80, 1'b1, 1'b1, 8'h80},
    '{OP_DIV,      16'h0003, IDENTITY_MAP, 8'hF9, 1'b0, 1'b0, 8'h00},
    '{OP_DIV,      16'h8000, IDENTITY_MAP, 8'h80, 1'b0, 1'b0, 8'h00},
    '{OP_DIV,      16'h7FFF, IDENTITY_MAP, 8'h7F, 1'b1, 1'b0, 8'h00},
    '{OP_OR,       16'hAB00, IDENTITY_MAP, 8'h5A, 1'b0, 1'b1, 8'h5A},
    '{OP_AND,      16'h5500, IDENTITY_MAP, 8'hFF, 1'b0, 1'b1, 8'h00},
    '{OP_XOR,      16'hFFFF, IDENTITY_MAP, 8'h0F, 1'b1, 1'b1, 8'hF0},
    '{OP_SHL,      16'hFFFF, IDENTITY_MAP, 8'h81, 1'b0, 1'b1, 8'h02},
    '{OP_SAL,      16'hFFFF, IDENTITY_MAP, 8'h81, 1'b0, 1'b1, 8'h03},
    '{OP_SHR,      16'hFFFF, IDENTITY_MAP, 8'h81, 1'b0, 1'b1, 8'h40},
    '{OP_SAR,      16'hFFFF, IDENTITY_MAP, 8'h81, 1'b1, 1'b1, 8'hC0},
    '{OP_ROL,      16'hFFFF, IDENTITY_MAP, 8'h81, 1'b0, 1'b1, 8'h03},
    '{OP_ROR,      16'hFFFF, IDENTITY_MAP, 8'h81, 1'b0, 1'b1, 8'hC0},
    '{OP_PERM,     16'hFFFF, IDENTITY_MAP, 8'h96, 1'b0, 1'b1, 8'h96},
    '{OP_PERM,     16'hFFFF, 24'h000000,   8'h01, 1'b0, 1'b1, 8'hFF},
    '{OP_PERM,     16'hFFFF, 24'hFFFFFF,   8'h7F, 1'b1, 1'b1, 8'h00},
    '{OP_PERM,     16'hFFFF, REVERSE_MAP,  8'h01, 1'b0, 1'b0, 8'h00},
    '{OP_UNDEF_LO, 16'h0000, REVERSE_MAP,  8'hFF, 1'b0, 1'b1, 8'h00},
    '{OP_UNDEF_HI, 16'h0000, REVERSE_MAP,  8'hFF, 1'b1, 1'b1, 8'h00}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bas_in_if  in_ch ();
  bas_out_if out_ch ();

  byte_alu_stream dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  logic [3:0]  cur_op;
  logic [15:0] cur_operand;
  logic [23:0] cur_map;

  out_word_t pending_words [$];
  int words_sent;
  int words_done = 0;
  int phase_left;
  int fail_count = 0;
  int quiet_cycles = 0;
  bit holdoff_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic byte_t alu_result(byte_t d);
    byte_t k;
    byte_t r;
    int quot;
    k = cur_operand[7:0];
    r = '0;
    case (cur_op)
      OP_ADD: r = d + k;
      OP_SUB: r = d - k;
      OP_MUL: r = d * k;
      OP_DIV: begin
        if (cur_operand == '0) begin
          r = d;
        end else begin
          quot = int'($signed(d)) / int'($signed(cur_operand));
          r = quot[7:0];
        end
      end
      OP_OR:  r = d | k;
      OP_AND: r = d & k;
      OP_XOR: r = d ^ k;
      OP_SHL: r = {d[6:0], 1'b0};
      OP_SAL: r = {d[6:0], d[0]};
      OP_SHR: r = {1'b0, d[7:1]};
      OP_SAR: r = {d[7], d[7:1]};
      OP_ROL: r = {d[6:0], d[7]};
      OP_ROR: r = {d[0], d[7:1]};
      OP_PERM: begin
        for (int i = 0; i < 8; i++) r[i] = d[cur_map[3*i +: 3]];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic bit tx_steady();
    return words_sent >= 700 && words_sent < 1000;
  endfunction

  function automatic bit rx_steady();
    return words_done >= 700 && words_done < 1000;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic set_config(logic [3:0] op, logic [15:0] operand, logic [23:0] map);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OP_SELECT;
    cfg_data  <= CFG_DATA_W'(op);
    @(negedge clk);
    cfg_index <= REG_OPERAND_VALUE;
    cfg_data  <= CFG_DATA_W'(operand);
    @(negedge clk);
    cfg_index <= REG_BIT_MAP;
    cfg_data  <= map;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_op      = op;
    cur_operand = operand;
    cur_map     = map;
  endtask

  task automatic send_word(byte_t d, logic last, logic known, byte_t result);
    out_word_t w;
    while (!tx_steady() && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_in   <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    w.result_byte = known ? result : alu_result(d);
    w.last_out    = last;
    pending_words.push_back(w);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    int unsigned kind;
    kind = $urandom_range(7);
    case (kind)
      0: return 16'($urandom);
      1: return 16'h0000;
      2: return 16'hFFFF;
      3: return 16'h7FFF;
      4: return 16'h8000;
      default: return 16'($urandom_range(16)) - 16'd8;
    endcase
  endfunction

  function automatic logic [23:0] pick_map();
    int unsigned kind;
    kind = $urandom_range(5);
    case (kind)
      0: return IDENTITY_MAP;
      1: return 24'h000000;
      2: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic byte_t pick_data();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: return 8'h00;
        1: return 8'h7F;
        2: return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return byte_t'($urandom_range(255));
  endfunction

  // stimulus
  initial begin
    int span;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_OP_SELECT;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_in   = 1'b0;
    cur_op          = OP_ADD;
    cur_operand     = '0;
    cur_map         = IDENTITY_MAP;
    words_sent      = 0;
    phase_left      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op != cur_op || directed_rows[i].operand != cur_operand ||
          directed_rows[i].map != cur_map) begin
        set_config(directed_rows[i].op, directed_rows[i].operand, directed_rows[i].map);
      end
      send_word(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].known, directed_rows[i].result);
    end

    while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
      span = ($urandom_range(9) == 0) ? $urandom_range(150, 250) : $urandom_range(8, 80);
      if (span > DIRECTED_ROWS + RANDOM_WORDS - words_sent) begin
        span = DIRECTED_ROWS + RANDOM_WORDS - words_sent;
      end
      set_config(4'($urandom_range(15)), pick_operand(), pick_map());
      phase_left = span;
      repeat (span) begin
        send_word(pick_data(), $urandom_range(7) == 0, 1'b0, 8'h00);
        phase_left--;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver with one long hold-off while the sender keeps offering words
  initial begin
    out_ch.ready = 1'b0;
    holdoff_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!holdoff_done && words_sent >= 400 && phase_left >= 20 && in_ch.valid) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end
      out_ch.ready <= rx_steady() || $urandom_range(99) >= IDLE_PCT;
      @(negedge clk);
    end
  end

  // result check
  always @(posedge clk) begin
    out_word_t w;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      words_done++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: result_byte %h last_out %b",
               out_ch.result_byte, out_ch.last_out);
        fail_count++;
      end else begin
        w = pending_words.pop_front();
        if (out_ch.result_byte !== w.result_byte) begin
          $error("result_byte: expected %h, got %h", w.result_byte, out_ch.result_byte);
          fail_count++;
        end
        if (out_ch.last_out !== w.last_out) begin
          $error("last_out: expected %b, got %b", w.last_out, out_ch.last_out);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
